@@ sv/point_rotation_about_center_defines.svh @@
// Assertion macros for the point rotation block.
// Compile with NO_ASSERTIONS defined to leave the checks out.
`ifndef POINT_ROTATION_ABOUT_CENTER_DEFINES_SVH
`define POINT_ROTATION_ABOUT_CENTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PRAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication with a delay given by the lat argument.
`define PRAC_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
		else $error(msg);
`else
`define PRAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PRAC_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg)
`endif
`endif

@@ sv/prac_pkg.sv @@
// Package for the point rotation block: shared widths, constants,
// the CORDIC vector type and the arctangent table. No dependencies.
package prac_pkg;

	localparam int CoordW = 32;
	localparam int TurnW = 32;
	localparam int DegHalfTurn = 180;
	// 360 = 45 * 8. The factor of 8 is taken care of by bit alignment, so only
	// a division by 45 remains.
	localparam int DegPow2Log = 3;
	localparam int DivBase = (2 * DegHalfTurn) >> DegPow2Log;
	localparam int RoundBias = DegHalfTurn >> DegPow2Log;
	localparam int DivRemW = $clog2(DivBase);
	localparam int TurnStepsPerStage = 8;

	localparam int GuardBits = 16;
	localparam int OffW = CoordW + 1;
	// Three bits of headroom cover the CORDIC growth and the quadrant fold.
	localparam int CordW = OffW + GuardBits + 3;

	localparam int GainW = 32;
	localparam logic [63:0] GainBase = 64'd2608131496;
	localparam logic [63:0] GainTailNum = 64'd1738754331;

	typedef struct packed {
		logic signed [CordW-1:0] x;
		logic signed [CordW-1:0] y;
		logic [TurnW-1:0] z;
	} cordic_vec_t;

	// Arctangent of 2^-i in binary-angle units (one turn = 2^32).
	function automatic logic [TurnW-1:0] atan_turn(input logic [4:0] idx);
		logic [TurnW-1:0] a;
		case (idx)
			5'd0: a = 32'd536870912;
			5'd1: a = 32'd316933406;
			5'd2: a = 32'd167458907;
			5'd3: a = 32'd85004756;
			5'd4: a = 32'd42667331;
			5'd5: a = 32'd21354465;
			5'd6: a = 32'd10679838;
			5'd7: a = 32'd5340245;
			5'd8: a = 32'd2670163;
			5'd9: a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			// The last entry rounds to zero.
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ sv/prac_turn.sv @@
// Pipelined conversion of an angle in fixed-point degrees to a binary angle.
// Depends on prac_pkg.
module prac_turn import prac_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [CoordW-1:0] angle,
	output logic                     out_valid,
	output logic [TurnW-1:0]         turn
);

	localparam int PadW = TurnW - DegPow2Log - FRAC_BITS;
	localparam int NumBits = CoordW - 1 + PadW;
	localparam int NumStages = (NumBits + TurnStepsPerStage - 1) / TurnStepsPerStage;

	logic               vld_s  [NumStages];
	logic [DivRemW-1:0] rem_s  [NumStages];
	logic [NumBits-1:0] bits_s [NumStages];
	logic [TurnW-1:0]   quo_s  [NumStages];

	logic [DivRemW-1:0] rem_src  [NumStages];
	logic [NumBits-1:0] bits_src [NumStages];
	logic [TurnW-1:0]   quo_src  [NumStages];
	logic [DivRemW-1:0] rem_d    [NumStages];
	logic [NumBits-1:0] bits_d   [NumStages];
	logic [TurnW-1:0]   quo_d    [NumStages];

	logic [DivRemW-1:0] rem_in;
	logic [NumBits-1:0] bits_in;

	// Long division by 45 of the angle bits followed by the rounding bias.
	// The sign bit enters as a remainder of -1 mod 45, which makes the
	// remainder after the integer-degree bits the floor modulo of the angle.
	// Only the last 32 quotient bits are kept: they are the binary angle.
	assign rem_in = angle[CoordW-1] ? DivRemW'(DivBase - 1) : '0;
	assign bits_in = {angle[CoordW-2:0], PadW'(RoundBias)};

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign rem_src[k] = rem_in;
			assign bits_src[k] = bits_in;
			assign quo_src[k] = '0;
		end else begin : g_next
			assign rem_src[k] = rem_s[k-1];
			assign bits_src[k] = bits_s[k-1];
			assign quo_src[k] = quo_s[k-1];
		end

		always_comb begin
			logic [DivRemW:0]   trial;
			logic [DivRemW-1:0] rem;
			logic [NumBits-1:0] bits;
			logic [TurnW-1:0]   quo;
			logic               qbit;
			trial = '0;
			qbit = 1'b0;
			rem = rem_src[k];
			bits = bits_src[k];
			quo = quo_src[k];
			for (int j = 0; j < TurnStepsPerStage; j++) begin
				if (k * TurnStepsPerStage + j < NumBits) begin
					trial = {rem, bits[NumBits-1]};
					bits = bits << 1;
					qbit = trial >= (DivRemW + 1)'(DivBase);
					rem = qbit ? DivRemW'(trial - (DivRemW + 1)'(DivBase)) : DivRemW'(trial);
					quo = {quo[TurnW-2:0], qbit};
				end
			end
			rem_d[k] = rem;
			bits_d[k] = bits;
			quo_d[k] = quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NumStages; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NumStages; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NumStages; k++) begin
			rem_s[k] <= rem_d[k];
			bits_s[k] <= bits_d[k];
			quo_s[k] <= quo_d[k];
		end
	end

	assign out_valid = vld_s[NumStages-1];
	assign turn = quo_s[NumStages-1];

endmodule

@@ sv/prac_cordic.sv @@
// Unrolled CORDIC rotation pipeline, one micro-rotation per register stage.
// Depends on prac_pkg.
module prac_cordic import prac_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  cordic_vec_t in_vec,
	output logic        out_valid,
	output cordic_vec_t out_vec
);

	logic        vld_s [STAGES];
	cordic_vec_t vec_s [STAGES];
	cordic_vec_t src   [STAGES];
	cordic_vec_t vec_d [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign src[i] = in_vec;
		end else begin : g_next
			assign src[i] = vec_s[i-1];
		end

		always_comb begin
			logic signed [CordW-1:0] sx;
			logic signed [CordW-1:0] sy;
			sx = $signed(src[i].y) >>> i;
			sy = $signed(src[i].x) >>> i;
			vec_d[i] = src[i];
			// A non-negative residual angle rotates counterclockwise.
			if (!src[i].z[TurnW-1]) begin
				vec_d[i].x = src[i].x - sx;
				vec_d[i].y = src[i].y + sy;
				vec_d[i].z = src[i].z - atan_turn(5'(i));
			end else begin
				vec_d[i].x = src[i].x + sx;
				vec_d[i].y = src[i].y - sy;
				vec_d[i].z = src[i].z + atan_turn(5'(i));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < STAGES; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STAGES; i++) vec_s[i] <= vec_d[i];
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_vec = vec_s[STAGES-1];

endmodule

@@ sv/point_rotation_about_center.sv @@
// Top level of the point rotation block; uses prac_pkg, prac_turn and prac_cordic.
// A point passes through the angle divider stages, a fold register, the CORDIC stages
// and the magnitude, multiply, round and output registers from start to done.
// Throughput: one point per cycle; busy stays low and results are never held off.
// Reset clears every valid bit, so points in flight at reset give no result.
`include "point_rotation_about_center_defines.svh"

module point_rotation_about_center import prac_pkg::*; #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [CoordW-1:0] point_x,
	input  logic signed [CoordW-1:0] point_y,
	input  logic signed [CoordW-1:0] center_x,
	input  logic signed [CoordW-1:0] center_y,
	input  logic signed [CoordW-1:0] angle_deg,
	output logic                     done,
	output logic signed [CoordW-1:0] rotated_x,
	output logic signed [CoordW-1:0] rotated_y,
	output logic                     overflow
);

	localparam int TurnBits = CoordW - 1 + TurnW - DegPow2Log - FRAC_BITS;
	localparam int TurnLat = (TurnBits + TurnStepsPerStage - 1) / TurnStepsPerStage;
	localparam int CenDepth = TurnLat + CORDIC_STAGES + 4;
	localparam int Latency = TurnLat + CORDIC_STAGES + 5;

	localparam logic [63:0] GainTail =
		(GainTailNum + (64'd1 << (2 * CORDIC_STAGES - 1))) >> (2 * CORDIC_STAGES);
	localparam logic [GainW-1:0] Gain = GainW'(GainBase + GainTail);

	localparam int MagHiW = CordW - 32;
	localparam int ProdHiW = MagHiW + GainW;
	localparam int SumW = ProdHiW + 1;
	localparam int RndW = SumW - GuardBits;
	localparam int ResW = RndW + 2;

	localparam logic signed [CoordW-1:0] SatMax = {1'b0, {(CoordW - 1){1'b1}}};
	localparam logic signed [CoordW-1:0] SatMin = {1'b1, {(CoordW - 1){1'b0}}};

	typedef struct packed {
		logic signed [OffW-1:0] dx;
		logic signed [OffW-1:0] dy;
	} off_t;

	typedef struct packed {
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
	} cen_t;

	logic accept;
	off_t off_q [TurnLat];
	cen_t cen_q [CenDepth];
	off_t off_in;

	logic             turn_vld;
	logic [TurnW-1:0] turn;

	logic                    fold_neg;
	logic signed [CordW-1:0] fold_x;
	logic signed [CordW-1:0] fold_y;
	cordic_vec_t             fold_vec_d;
	logic                    fold_vld_s1;
	cordic_vec_t             fold_vec_s1;

	logic                    cor_vld;
	cordic_vec_t             cor_vec;
	logic signed [CordW-1:0] cor_lane [2];

	logic               abs_vld_s2;
	logic               neg_s2 [2];
	logic [CordW-1:0]   mag_s2 [2];
	logic               mul_vld_s3;
	logic               neg_s3 [2];
	logic [63:0]        plo_s3 [2];
	logic [ProdHiW-1:0] phi_s3 [2];
	logic               rnd_vld_s4;
	logic               neg_s4 [2];
	logic [RndW-1:0]    rnd_s4 [2];

	logic signed [CoordW-1:0] cen_lane [2];
	logic signed [CoordW-1:0] sat_val  [2];
	logic                     sat_hit  [2];
	logic                     out_at_bound;

	assign busy = 1'b0;
	assign accept = start && !busy;

	assign off_in.dx = $signed({point_x[CoordW-1], point_x})
		- $signed({center_x[CoordW-1], center_x});
	assign off_in.dy = $signed({point_y[CoordW-1], point_y})
		- $signed({center_y[CoordW-1], center_y});

	// The offset waits for the binary angle; the center waits for the final add.
	always_ff @(posedge clk) begin
		off_q[0] <= off_in;
		for (int j = 1; j < TurnLat; j++) off_q[j] <= off_q[j-1];
		cen_q[0] <= '{cx: center_x, cy: center_y};
		for (int j = 1; j < CenDepth; j++) cen_q[j] <= cen_q[j-1];
	end

	prac_turn #(
		.FRAC_BITS(FRAC_BITS)
	) u_turn (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.angle    (angle_deg),
		.out_valid(turn_vld),
		.turn     (turn)
	);

	// Angles in the second and third quadrants are turned by half a turn and
	// the offset negated, leaving a residual angle within a quarter turn.
	always_comb begin
		fold_neg = turn[TurnW-1] ^ turn[TurnW-2];
		fold_x = CordW'($signed({off_q[TurnLat-1].dx, {GuardBits{1'b0}}}));
		fold_y = CordW'($signed({off_q[TurnLat-1].dy, {GuardBits{1'b0}}}));
		fold_vec_d.x = fold_neg ? -fold_x : fold_x;
		fold_vec_d.y = fold_neg ? -fold_y : fold_y;
		fold_vec_d.z = turn ^ {fold_neg, {(TurnW - 1){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_vld_s1 <= 1'b0;
			abs_vld_s2 <= 1'b0;
			mul_vld_s3 <= 1'b0;
			rnd_vld_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			fold_vld_s1 <= turn_vld;
			abs_vld_s2 <= cor_vld;
			mul_vld_s3 <= abs_vld_s2;
			rnd_vld_s4 <= mul_vld_s3;
			done <= rnd_vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		fold_vec_s1 <= fold_vec_d;
	end

	prac_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fold_vld_s1),
		.in_vec   (fold_vec_s1),
		.out_valid(cor_vld),
		.out_vec  (cor_vec)
	);

	assign cor_lane[0] = cor_vec.x;
	assign cor_lane[1] = cor_vec.y;
	assign cen_lane[0] = cen_q[CenDepth-1].cx;
	assign cen_lane[1] = cen_q[CenDepth-1].cy;

	// Gain removal on the magnitude: the wide product is split into a low and
	// a high partial product, summed with rounding in the next stage.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			neg_s2[l] <= cor_lane[l][CordW-1];
			mag_s2[l] <= cor_lane[l][CordW-1] ? unsigned'(-cor_lane[l])
				: unsigned'(cor_lane[l]);
			neg_s3[l] <= neg_s2[l];
			plo_s3[l] <= 64'(mag_s2[l][31:0]) * 64'(Gain);
			phi_s3[l] <= ProdHiW'(mag_s2[l][CordW-1:32]) * ProdHiW'(Gain);
			neg_s4[l] <= neg_s3[l];
			rnd_s4[l] <= RndW'((SumW'(phi_s3[l]) + SumW'(plo_s3[l][63:32])
				+ SumW'(1) * (SumW'(1) << (GuardBits - 1))) >> GuardBits);
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic signed [ResW-1:0] rnd_signed;
			logic signed [ResW-1:0] res;
			logic [ResW-CoordW:0]   top;
			rnd_signed = $signed({2'b00, rnd_s4[l]});
			res = ResW'(cen_lane[l]) + (neg_s4[l] ? -rnd_signed : rnd_signed);
			top = res[ResW-1:CoordW-1];
			sat_hit[l] = !((&top) || !(|top));
			if (sat_hit[l]) begin
				sat_val[l] = res[ResW-1] ? SatMin : SatMax;
			end else begin
				sat_val[l] = res[CoordW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_vld_s4) begin
			rotated_x <= sat_val[0];
			rotated_y <= sat_val[1];
			overflow <= sat_hit[0] || sat_hit[1];
		end
	end

	assign out_at_bound = (rotated_x == SatMax) || (rotated_x == SatMin)
		|| (rotated_y == SatMax) || (rotated_y == SatMin);

	`PRAC_ASSERT_IMP(a_ovf_bound, clk, arst_n, done && overflow, out_at_bound,
		"overflow without saturation")
	`PRAC_ASSERT_IMP(a_fold_quarter, clk, arst_n, fold_vld_s1,
		fold_vec_s1.z[TurnW-1] == fold_vec_s1.z[TurnW-2], "fold left a wide angle")
	`PRAC_ASSERT_LAT(a_latency, clk, arst_n, start && !busy, Latency, done,
		"transfer gave no result")
	`PRAC_ASSERT_IMP(a_done_src, clk, arst_n, done, $past(start && !busy, Latency),
		"result without transfer")

endmodule
